// ===== hdl/dga_pkg.sv =====
`default_nettype none
package dga_pkg;

    localparam int IN_W   = 48;
    localparam int OUT_W  = 48;
    localparam int POS_W  = IN_W + 1;
    localparam int MAG_W  = POS_W;
    localparam int MU_W   = 51;
    localparam int SQ_W   = 98;
    localparam int ROOT_W = 50;
    localparam int NUM_W  = 100;
    localparam int DEN_W  = 148;
    localparam int REM_W  = DEN_W + 1;
    localparam int Q_W    = 62;
    localparam int ACC_W  = Q_W + 1;
    localparam int DIFF_W = ACC_W + 1;

    // |p| < 1 m  <=>  S < 2^(2*16)
    localparam int NEAR_SH = 32;
    // numerator scale 2^68 against a quotient limit of 2^62
    localparam int PRE_SH  = 6;

    localparam int SQ_DIG   = 16;
    localparam int SQ_STEPS = (MAG_W + SQ_DIG - 1) / SQ_DIG;
    localparam int D_DIG    = 8;
    localparam int D_STEPS  = (ROOT_W + D_DIG - 1) / D_DIG;

    // input reg, abs, squares, sum, root, S*R, pre-divide, divide, sign
    localparam int BODY_LAT = 1 + 1 + SQ_STEPS + 1 + ROOT_W + D_STEPS + 1 + Q_W + 1;

    localparam logic [MU_W-1:0]  MU_RESET = 51'd398600441800000;
    localparam logic [Q_W-1:0]   BODY_LIM = {Q_W{1'b1}};
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [OUT_W-1:0] acc_x;
        logic signed [OUT_W-1:0] acc_y;
        logic signed [OUT_W-1:0] acc_z;
        logic                    inspector_near_center;
        logic                    target_near_center;
        logic                    saturated;
    } acc_word_t;

endpackage
`default_nettype wire

// ===== hdl/dga_pos_if.sv =====
`default_nettype none
interface dga_pos_if;
    logic                              valid;
    logic                              ready;
    logic signed [dga_pkg::IN_W-1:0]   rel_x;
    logic signed [dga_pkg::IN_W-1:0]   rel_y;
    logic signed [dga_pkg::IN_W-1:0]   rel_z;
    logic signed [dga_pkg::IN_W-1:0]   tgt_x;
    logic signed [dga_pkg::IN_W-1:0]   tgt_y;
    logic signed [dga_pkg::IN_W-1:0]   tgt_z;

    modport source (output valid, rel_x, rel_y, rel_z, tgt_x, tgt_y, tgt_z, input ready);
    modport sink   (input valid, rel_x, rel_y, rel_z, tgt_x, tgt_y, tgt_z, output ready);
endinterface
`default_nettype wire

// ===== hdl/dga_acc_if.sv =====
`default_nettype none
interface dga_acc_if;
    logic                              valid;
    logic                              ready;
    logic signed [dga_pkg::OUT_W-1:0]  acc_x;
    logic signed [dga_pkg::OUT_W-1:0]  acc_y;
    logic signed [dga_pkg::OUT_W-1:0]  acc_z;
    logic                              inspector_near_center;
    logic                              target_near_center;
    logic                              saturated;

    modport source (output valid, acc_x, acc_y, acc_z, inspector_near_center,
                    target_near_center, saturated, input ready);
    modport sink   (input valid, acc_x, acc_y, acc_z, inspector_near_center,
                    target_near_center, saturated, output ready);
endinterface
`default_nettype wire

// ===== hdl/dga_body.sv =====
`default_nettype none
module dga_body (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic        [dga_pkg::MU_W-1:0]     mu,
    input  wire logic signed [dga_pkg::POS_W-1:0]    pos [0:2],
    output logic signed      [dga_pkg::ACC_W-1:0]    acc [0:2],
    output logic                                     near,
    output logic                                     clip
);

    localparam int MAG_W    = dga_pkg::MAG_W;
    localparam int SQ_W     = dga_pkg::SQ_W;
    localparam int NUM_W    = dga_pkg::NUM_W;
    localparam int ROOT_W   = dga_pkg::ROOT_W;
    localparam int DEN_W    = dga_pkg::DEN_W;
    localparam int REM_W    = dga_pkg::REM_W;
    localparam int Q_W      = dga_pkg::Q_W;
    localparam int ACC_W    = dga_pkg::ACC_W;
    localparam int SQ_DIG   = dga_pkg::SQ_DIG;
    localparam int SQ_STEPS = dga_pkg::SQ_STEPS;
    localparam int D_DIG    = dga_pkg::D_DIG;
    localparam int D_STEPS  = dga_pkg::D_STEPS;
    localparam int MG_EXT_W = SQ_STEPS * SQ_DIG;
    localparam int R_EXT_W  = D_STEPS * D_DIG;
    localparam int T_W      = SQ_W + 2;

    // input register
    logic signed [dga_pkg::POS_W-1:0] p_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p_reg[i] <= pos[i];
            end
        end
    end

    // magnitude
    logic [MAG_W-1:0] mag_reg [0:2];
    logic [2:0]       neg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= p_reg[i][dga_pkg::POS_W-1];
                mag_reg[i] <= p_reg[i][dga_pkg::POS_W-1] ? MAG_W'(-p_reg[i])
                                                         : MAG_W'(p_reg[i]);
            end
        end
    end

    // squares and mu*|p|, one digit of |p| per stage
    logic [SQ_W-1:0]  sq_reg [0:SQ_STEPS-1][0:2];
    logic [NUM_W-1:0] nm_reg [0:SQ_STEPS-1][0:2];
    logic [MAG_W-1:0] mg_reg [0:SQ_STEPS-1][0:2];
    logic [2:0]       sn_reg [0:SQ_STEPS-1];

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sq
        logic [SQ_W-1:0]                  sq_src [0:2];
        logic [NUM_W-1:0]                 nm_src [0:2];
        logic [MAG_W-1:0]                 mg_src [0:2];
        logic [2:0]                       sn_src;
        logic [MG_EXT_W-1:0]              mg_ext [0:2];
        logic [MAG_W+SQ_DIG-1:0]          sp [0:2];
        logic [dga_pkg::MU_W+SQ_DIG-1:0]  np [0:2];

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_src[i] = '0;
                    nm_src[i] = '0;
                    mg_src[i] = mag_reg[i];
                end
                sn_src = neg_reg;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_src[i] = sq_reg[k-1][i];
                    nm_src[i] = nm_reg[k-1][i];
                    mg_src[i] = mg_reg[k-1][i];
                end
                sn_src = sn_reg[k-1];
            end
        end

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                mg_ext[i] = MG_EXT_W'(mg_src[i]);
                sp[i] = mg_src[i] * mg_ext[i][k*SQ_DIG +: SQ_DIG];
                np[i] = mu * mg_ext[i][k*SQ_DIG +: SQ_DIG];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_reg[k][i] <= sq_src[i] + (SQ_W'(sp[i]) << (k*SQ_DIG));
                    nm_reg[k][i] <= nm_src[i] + (NUM_W'(np[i]) << (k*SQ_DIG));
                    mg_reg[k][i] <= mg_src[i];
                end
                sn_reg[k] <= sn_src;
            end
        end
    end

    // sum of squares, near-center test
    logic [SQ_W-1:0]  su_s_reg;
    logic             su_near_reg;
    logic [NUM_W-1:0] su_nm_reg [0:2];
    logic [2:0]       su_neg_reg;
    logic [SQ_W-1:0]  su_sum;

    assign su_sum = sq_reg[SQ_STEPS-1][0] + sq_reg[SQ_STEPS-1][1] + sq_reg[SQ_STEPS-1][2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            su_s_reg    <= su_sum;
            su_near_reg <= (su_sum[SQ_W-1:dga_pkg::NEAR_SH] == '0);
            for (int i = 0; i < 3; i++)
            begin
                su_nm_reg[i] <= nm_reg[SQ_STEPS-1][i];
            end
            su_neg_reg <= sn_reg[SQ_STEPS-1];
        end
    end

    // integer square root, one root bit per stage
    logic [SQ_W-1:0]   rt_s_reg    [0:ROOT_W-1];
    logic [SQ_W-1:0]   rt_rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0] rt_res_reg  [0:ROOT_W-1];
    logic [NUM_W-1:0]  rt_nm_reg   [0:ROOT_W-1][0:2];
    logic [2:0]        rt_neg_reg  [0:ROOT_W-1];
    logic              rt_near_reg [0:ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_rt
        localparam int B = ROOT_W - 1 - k;
        logic [SQ_W-1:0]   s_src;
        logic [SQ_W-1:0]   rem_src;
        logic [ROOT_W-1:0] res_src;
        logic [NUM_W-1:0]  nm_src [0:2];
        logic [2:0]        neg_src;
        logic              near_src;
        logic [T_W-1:0]    trial;
        logic              ge;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                s_src    = su_s_reg;
                rem_src  = su_s_reg;
                res_src  = '0;
                nm_src   = su_nm_reg;
                neg_src  = su_neg_reg;
                near_src = su_near_reg;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                s_src    = rt_s_reg[k-1];
                rem_src  = rt_rem_reg[k-1];
                res_src  = rt_res_reg[k-1];
                nm_src   = rt_nm_reg[k-1];
                neg_src  = rt_neg_reg[k-1];
                near_src = rt_near_reg[k-1];
            end
        end

        assign trial = (T_W'(res_src) << (B + 1)) | (T_W'(1) << (2 * B));
        assign ge    = T_W'(rem_src) >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_s_reg[k]    <= s_src;
                rt_rem_reg[k]  <= ge ? SQ_W'(T_W'(rem_src) - trial) : rem_src;
                rt_res_reg[k]  <= res_src | (ge ? (ROOT_W'(1) << B) : '0);
                rt_nm_reg[k]   <= nm_src;
                rt_neg_reg[k]  <= neg_src;
                rt_near_reg[k] <= near_src;
            end
        end
    end

    // D = S * R, one digit of R per stage
    logic [DEN_W-1:0]  dm_acc_reg  [0:D_STEPS-1];
    logic [SQ_W-1:0]   dm_s_reg    [0:D_STEPS-1];
    logic [ROOT_W-1:0] dm_r_reg    [0:D_STEPS-1];
    logic [NUM_W-1:0]  dm_nm_reg   [0:D_STEPS-1][0:2];
    logic [2:0]        dm_neg_reg  [0:D_STEPS-1];
    logic              dm_near_reg [0:D_STEPS-1];

    for (genvar k = 0; k < D_STEPS; k++)
    begin : g_dm
        logic [DEN_W-1:0]     acc_src;
        logic [SQ_W-1:0]      s_src;
        logic [ROOT_W-1:0]    r_src;
        logic [NUM_W-1:0]     nm_src [0:2];
        logic [2:0]           neg_src;
        logic                 near_src;
        logic [R_EXT_W-1:0]   r_ext;
        logic [SQ_W+D_DIG-1:0] dp;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                acc_src  = '0;
                s_src    = rt_s_reg[ROOT_W-1];
                r_src    = rt_res_reg[ROOT_W-1];
                nm_src   = rt_nm_reg[ROOT_W-1];
                neg_src  = rt_neg_reg[ROOT_W-1];
                near_src = rt_near_reg[ROOT_W-1];
            end
        end
        else
        begin : g_next
            always_comb
            begin
                acc_src  = dm_acc_reg[k-1];
                s_src    = dm_s_reg[k-1];
                r_src    = dm_r_reg[k-1];
                nm_src   = dm_nm_reg[k-1];
                neg_src  = dm_neg_reg[k-1];
                near_src = dm_near_reg[k-1];
            end
        end

        assign r_ext = R_EXT_W'(r_src);
        assign dp    = s_src * r_ext[k*D_DIG +: D_DIG];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dm_acc_reg[k]  <= acc_src + (DEN_W'(dp) << (k*D_DIG));
                dm_s_reg[k]    <= s_src;
                dm_r_reg[k]    <= r_src;
                dm_nm_reg[k]   <= nm_src;
                dm_neg_reg[k]  <= neg_src;
                dm_near_reg[k] <= near_src;
            end
        end
    end

    // pre-divide: first partial remainder and per-body limit
    logic [REM_W-1:0] pd_r_reg [0:2];
    logic [DEN_W-1:0] pd_d_reg;
    logic [2:0]       pd_clip_reg;
    logic [2:0]       pd_neg_reg;
    logic             pd_near_reg;
    logic [REM_W-1:0] pd_r0 [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pd_r0[i] = REM_W'(dm_nm_reg[D_STEPS-1][i]) << dga_pkg::PRE_SH;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pd_r_reg[i]    <= pd_r0[i];
                pd_clip_reg[i] <= pd_r0[i] >= REM_W'(dm_acc_reg[D_STEPS-1]);
            end
            pd_d_reg    <= dm_acc_reg[D_STEPS-1];
            pd_neg_reg  <= dm_neg_reg[D_STEPS-1];
            pd_near_reg <= dm_near_reg[D_STEPS-1];
        end
    end

    // restoring divide, one quotient bit per stage
    logic [REM_W-1:0] dv_r_reg    [0:Q_W-1][0:2];
    logic [Q_W-1:0]   dv_q_reg    [0:Q_W-1][0:2];
    logic [DEN_W-1:0] dv_d_reg    [0:Q_W-1];
    logic [2:0]       dv_clip_reg [0:Q_W-1];
    logic [2:0]       dv_neg_reg  [0:Q_W-1];
    logic             dv_near_reg [0:Q_W-1];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_dv
        localparam int B = Q_W - 1 - k;
        logic [REM_W-1:0] r_src [0:2];
        logic [Q_W-1:0]   q_src [0:2];
        logic [DEN_W-1:0] d_src;
        logic [2:0]       clip_src;
        logic [2:0]       neg_src;
        logic             near_src;
        logic [REM_W-1:0] r2 [0:2];
        logic [2:0]       ge;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    r_src[i] = pd_r_reg[i];
                    q_src[i] = '0;
                end
                d_src    = pd_d_reg;
                clip_src = pd_clip_reg;
                neg_src  = pd_neg_reg;
                near_src = pd_near_reg;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    r_src[i] = dv_r_reg[k-1][i];
                    q_src[i] = dv_q_reg[k-1][i];
                end
                d_src    = dv_d_reg[k-1];
                clip_src = dv_clip_reg[k-1];
                neg_src  = dv_neg_reg[k-1];
                near_src = dv_near_reg[k-1];
            end
        end

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                r2[i] = {r_src[i][REM_W-2:0], 1'b0};
                ge[i] = r2[i] >= REM_W'(d_src);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dv_r_reg[k][i] <= ge[i] ? r2[i] - REM_W'(d_src) : r2[i];
                    dv_q_reg[k][i] <= q_src[i] | (ge[i] ? (Q_W'(1) << B) : '0);
                end
                dv_d_reg[k]    <= d_src;
                dv_clip_reg[k] <= clip_src;
                dv_neg_reg[k]  <= neg_src;
                dv_near_reg[k] <= near_src;
            end
        end
    end

    // limit, sign opposite to the position
    logic signed [ACC_W-1:0] acc_reg [0:2];
    logic                    near_reg;
    logic                    clip_reg;
    logic [Q_W-1:0]          fin_mag [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fin_mag[i] = dv_clip_reg[Q_W-1][i] ? dga_pkg::BODY_LIM : dv_q_reg[Q_W-1][i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dv_near_reg[Q_W-1])
                begin
                    acc_reg[i] <= '0;
                end
                else if (dv_neg_reg[Q_W-1][i])
                begin
                    acc_reg[i] <= ACC_W'(fin_mag[i]);
                end
                else
                begin
                    acc_reg[i] <= -ACC_W'(fin_mag[i]);
                end
            end
            near_reg <= dv_near_reg[Q_W-1];
            clip_reg <= !dv_near_reg[Q_W-1] && (dv_clip_reg[Q_W-1] != '0);
        end
    end

    assign acc  = acc_reg;
    assign near = near_reg;
    assign clip = clip_reg;

endmodule
`default_nettype wire

// ===== hdl/differential_gravity_accel.sv =====
// Differential point-mass gravity acceleration.
// pos channel: one word per item, target absolute position and inspector
//   offset, signed Q32.16 m. acc channel: one word per item, inspector minus
//   target acceleration in signed Q12.36 m/s^2 plus near-center and
//   saturation flags. Both channels move a word when valid and ready are high.
// cfg_we/cfg_wdata write mu (m^3/s^2); write only while no word is in flight.
// Throughput: one word per cycle while pos.ready is high. Each body holds a
//   50-stage root, a 7-stage S*R product and a 62-stage quotient pipeline.
// Reset clears all valid bits and loads mu with the Earth value; no memory
//   needs clearing, the first word can be sent right after reset.
// When acc.ready is low the output register holds its word and one more word
//   lands in the skid register; then pos.ready drops and the whole pipeline
//   freezes until the skid drains. Nothing is lost or repeated.
`default_nettype none
module differential_gravity_accel (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [dga_pkg::MU_W-1:0]    cfg_wdata,
    dga_pos_if.sink                          pos,
    dga_acc_if.source                        acc
);

    localparam int LAT   = dga_pkg::BODY_LAT;
    localparam int POS_W = dga_pkg::POS_W;
    localparam int ACC_W = dga_pkg::ACC_W;
    localparam int OUT_W = dga_pkg::OUT_W;
    localparam int DIFF_W = dga_pkg::DIFF_W;

    logic [dga_pkg::MU_W-1:0] mu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg <= dga_pkg::MU_RESET;
        end
        else if (cfg_we)
        begin
            mu_reg <= cfg_wdata;
        end
    end

    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign en        = !skid_valid_reg;
    assign pos.ready = en;

    logic vld_reg [0:LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= pos.valid;
            for (int k = 1; k <= LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    logic signed [POS_W-1:0] tgt_pos  [0:2];
    logic signed [POS_W-1:0] insp_pos [0:2];

    assign tgt_pos[0]  = POS_W'(pos.tgt_x);
    assign tgt_pos[1]  = POS_W'(pos.tgt_y);
    assign tgt_pos[2]  = POS_W'(pos.tgt_z);
    assign insp_pos[0] = POS_W'(pos.tgt_x) + POS_W'(pos.rel_x);
    assign insp_pos[1] = POS_W'(pos.tgt_y) + POS_W'(pos.rel_y);
    assign insp_pos[2] = POS_W'(pos.tgt_z) + POS_W'(pos.rel_z);

    logic signed [ACC_W-1:0] ai [0:2];
    logic signed [ACC_W-1:0] at [0:2];
    logic                    near_i;
    logic                    near_t;
    logic                    clip_i;
    logic                    clip_t;

    dga_body u_insp (
        .clk  (clk),
        .en   (en),
        .mu   (mu_reg),
        .pos  (insp_pos),
        .acc  (ai),
        .near (near_i),
        .clip (clip_i)
    );

    dga_body u_tgt (
        .clk  (clk),
        .en   (en),
        .mu   (mu_reg),
        .pos  (tgt_pos),
        .acc  (at),
        .near (near_t),
        .clip (clip_t)
    );

    // difference and output limit
    dga_pkg::acc_word_t      res_reg;
    logic signed [OUT_W-1:0] res_c [0:2];
    logic [2:0]              res_sat;

    always_comb
    begin
        logic signed [DIFF_W-1:0]    d;
        logic [DIFF_W-OUT_W:0]       hi;
        for (int i = 0; i < 3; i++)
        begin
            d  = DIFF_W'(ai[i]) - DIFF_W'(at[i]);
            hi = d[DIFF_W-1:OUT_W-1];
            res_sat[i] = !((hi == '0) || (hi == '1));
            if (!res_sat[i])
            begin
                res_c[i] = d[OUT_W-1:0];
            end
            else if (d[DIFF_W-1])
            begin
                res_c[i] = dga_pkg::OUT_MIN;
            end
            else
            begin
                res_c[i] = dga_pkg::OUT_MAX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.acc_x                 <= res_c[0];
            res_reg.acc_y                 <= res_c[1];
            res_reg.acc_z                 <= res_c[2];
            res_reg.inspector_near_center <= near_i;
            res_reg.target_near_center    <= near_t;
            res_reg.saturated             <= clip_i || clip_t || (res_sat != '0);
        end
    end

    // output register with skid
    dga_pkg::acc_word_t out_reg;
    dga_pkg::acc_word_t skid_reg;
    logic               take;

    assign take = en && vld_reg[LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (acc.ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= take;
            end
        end
        else if (take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc.ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (take)
            begin
                out_reg <= res_reg;
            end
        end
        else if (take)
        begin
            skid_reg <= res_reg;
        end
    end

    assign acc.valid                 = out_valid_reg;
    assign acc.acc_x                 = out_reg.acc_x;
    assign acc.acc_y                 = out_reg.acc_y;
    assign acc.acc_z                 = out_reg.acc_z;
    assign acc.inspector_near_center = out_reg.inspector_near_center;
    assign acc.target_near_center    = out_reg.target_near_center;
    assign acc.saturated             = out_reg.saturated;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a word while output is empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !acc.ready))
        else $error("skid filled without an output stall");

    a_both_near_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (acc.valid && acc.inspector_near_center && acc.target_near_center)
        |-> (acc.acc_x == '0 && acc.acc_y == '0 && acc.acc_z == '0 && !acc.saturated))
        else $error("nonzero acceleration with both bodies near center");

endmodule
`default_nettype wire

// ===== sim/dga_acc_checker.sv =====
module dga_acc_checker (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_we,
    input  logic [dga_pkg::MU_W-1:0] cfg_wdata,
    dga_pos_if    pos,
    dga_acc_if    acc,
    output int    errors,
    output int    pending
);
    import dga_pkg::*;

    logic [MU_W-1:0] mu;
    acc_word_t       acc_expected_q[$];

    function automatic void point_mass_accel(input logic signed [48:0] p [3],
                                             input logic [MU_W-1:0] g,
                                             output logic signed [63:0] a [3],
                                             output bit near, inout bit clip);
        logic [255:0] s, r, c, d, num;
        logic [48:0]  m [3];
        logic [63:0]  q;
        s = '0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = p[i] < 0 ? -p[i] : p[i];
            s = s + 256'(m[i]) * 256'(m[i]);
        end
        near = (s >> NEAR_SH) == 0;
        if (near)
        begin
            for (int i = 0; i < 3; i++)
                a[i] = 0;
            return;
        end
        r = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            c = r | (256'd1 << b);
            if (c * c <= s)
                r = c;
        end
        d = s * r;
        for (int i = 0; i < 3; i++)
        begin
            num = 256'(g) * 256'(m[i]);
            if ((num << PRE_SH) >= d)
            begin
                q = 64'(BODY_LIM);
                clip = 1;
            end
            else
                q = 64'((num << 68) / d);
            a[i] = p[i] >= 0 ? -$signed(q) : $signed(q);
        end
    endfunction

    function automatic acc_word_t diff_accel(input logic signed [IN_W-1:0] rel [3],
                                             input logic signed [IN_W-1:0] tgt [3],
                                             input logic [MU_W-1:0] g);
        acc_word_t w;
        logic signed [48:0] pi [3], pt [3];
        logic signed [63:0] ai [3], at [3], v [3];
        bit ni, nt, clip;
        clip = 0;
        for (int i = 0; i < 3; i++)
        begin
            pt[i] = 49'(tgt[i]);
            pi[i] = 49'(tgt[i]) + 49'(rel[i]);
        end
        point_mass_accel(pi, g, ai, ni, clip);
        point_mass_accel(pt, g, at, nt, clip);
        for (int i = 0; i < 3; i++)
        begin
            v[i] = ai[i] - at[i];
            if (v[i] > 64'(OUT_MAX))
            begin
                v[i] = 64'(OUT_MAX);
                clip = 1;
            end
            if (v[i] < 64'(OUT_MIN))
            begin
                v[i] = 64'(OUT_MIN);
                clip = 1;
            end
        end
        w.acc_x = v[0][OUT_W-1:0];
        w.acc_y = v[1][OUT_W-1:0];
        w.acc_z = v[2][OUT_W-1:0];
        w.inspector_near_center = ni;
        w.target_near_center = nt;
        w.saturated = clip;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        acc_word_t e, got;
        logic signed [IN_W-1:0] rel [3], tgt [3];
        if (!rst_n)
        begin
            mu <= MU_RESET;
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (pos.valid && pos.ready)
            begin
                rel[0] = pos.rel_x; rel[1] = pos.rel_y; rel[2] = pos.rel_z;
                tgt[0] = pos.tgt_x; tgt[1] = pos.tgt_y; tgt[2] = pos.tgt_z;
                acc_expected_q.push_back(diff_accel(rel, tgt, mu));
            end
            if (acc.valid && acc.ready)
            begin
                got.acc_x = acc.acc_x;
                got.acc_y = acc.acc_y;
                got.acc_z = acc.acc_z;
                got.inspector_near_center = acc.inspector_near_center;
                got.target_near_center = acc.target_near_center;
                got.saturated = acc.saturated;
                if (acc_expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected acc word %h", got);
                end
                else
                begin
                    e = acc_expected_q.pop_front();
                    if (e !== got)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("acc mismatch: exp x=%h y=%h z=%h ni=%b nt=%b sat=%b",
                                     e.acc_x, e.acc_y, e.acc_z, e.inspector_near_center,
                                     e.target_near_center, e.saturated,
                                     "\n              got x=%h y=%h z=%h ni=%b nt=%b sat=%b",
                                     got.acc_x, got.acc_y, got.acc_z,
                                     got.inspector_near_center, got.target_near_center,
                                     got.saturated);
                    end
                end
            end
            if (cfg_we)
                mu <= cfg_wdata;
            pending = acc_expected_q.size();
        end
    end
endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    import dga_pkg::*;

    localparam int N_PHASE_ITEMS = 620;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [MU_W-1:0] cfg_wdata;
    int              errors;
    int              pending;
    int              tx_idle_pct;
    int              rx_idle_pct;
    longint          cycle;
    longint          rx_hold_end;

    dga_pos_if pos ();
    dga_acc_if acc ();

    differential_gravity_accel u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pos       (pos),
        .acc       (acc)
    );

    dga_acc_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pos       (pos),
        .acc       (acc),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
        cycle <= cycle + 1;

    // receiver side, with long hold-offs requested by the sender process
    always @(posedge clk)
        acc.ready <= (cycle < rx_hold_end) ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);

    function automatic logic signed [IN_W-1:0] rand_pos();
        logic signed [IN_W-1:0] v;
        v = IN_W'({$urandom, $urandom});
        return v >>> $urandom_range(IN_W - 1);
    endfunction

    task automatic send_word(input logic signed [IN_W-1:0] rx, ry, rz, tx, ty, tz);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            pos.valid <= 1'b0;
            @(posedge clk);
        end
        pos.valid <= 1'b1;
        pos.rel_x <= rx; pos.rel_y <= ry; pos.rel_z <= rz;
        pos.tgt_x <= tx; pos.tgt_y <= ty; pos.tgt_z <= tz;
        do
            @(posedge clk);
        while (!pos.ready);
    endtask

    task automatic drain();
        pos.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (BODY_LAT + 10) @(posedge clk);
    endtask

    task automatic write_mu(input logic [MU_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_orbit();
        logic signed [IN_W-1:0] t [3], r [3];
        int sc;
        sc = $urandom_range(40, 22);
        for (int i = 0; i < 3; i++)
        begin
            t[i] = rand_pos() >>> (IN_W - 1 - sc);
            r[i] = rand_pos() >>> $urandom_range(IN_W - 1, 10);
        end
        send_word(r[0], r[1], r[2], t[0], t[1], t[2]);
    endtask

    initial
    begin
        logic signed [IN_W-1:0] mx, mn, one;
        logic [MU_W-1:0] mus [3];
        mx = {1'b0, {(IN_W-1){1'b1}}};
        mn = {1'b1, {(IN_W-1){1'b0}}};
        one = 48'sd65536;
        mus[0] = 51'd1;
        mus[1] = 51'd1125899906842624;
        mus[2] = 51'd4902800066000;
        cycle = 0;
        rx_hold_end = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        pos.valid <= 1'b0;
        pos.rel_x <= '0; pos.rel_y <= '0; pos.rel_z <= '0;
        pos.tgt_x <= '0; pos.tgt_y <= '0; pos.tgt_z <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset mu
        send_word('0, '0, '0, '0, '0, '0);
        send_word('0, '0, '0, one, '0, '0);
        send_word('0, '0, '0, one - 48'sd1, '0, '0);
        send_word(-one, '0, '0, one, '0, '0);
        send_word('0, 48'sd5, '0, '0, '0, -one);
        send_word(mx, mx, mx, mx, mx, mx);
        send_word(mn, mn, mn, mn, mn, mn);
        send_word(mx, mn, mx, mn, mx, mn);
        send_word(48'sd100 * one, -48'sd3 * one, one, 48'sd6778000 * one, '0, '0);
        send_word(one, one, one, '0, 48'sd42164000 * one, 48'sd1000 * one);
        send_word(48'sd2 * one, '0, '0, -one, '0, '0);
        send_word('0, '0, mx, '0, '0, -one);
        write_mu(mus[1]);
        send_word('0, '0, '0, one, one, '0);
        send_word('0, '0, '0, -one, '0, '0);
        send_word(mx, '0, '0, one, '0, '0);
        send_word(-48'sd2 * one, '0, '0, one, '0, '0);
        send_word(mn, mn, mn, mn, mn, mn);
        write_mu(mus[0]);
        send_word('0, '0, '0, one, '0, '0);
        send_word(mx, mx, mx, mx, mx, mx);
        send_word(one, '0, '0, 48'sd6778000 * one, '0, '0);

        for (int ph = 0; ph < 3; ph++)
        begin
            write_mu(mus[ph]);
            tx_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 83 : 0;
            rx_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 20 : 0;
            for (int n = 0; n < N_PHASE_ITEMS; n++)
            begin
                if (n == N_PHASE_ITEMS / 3)
                    rx_hold_end <= cycle + 600;
                if (n == N_PHASE_ITEMS / 2)
                    drain();
                if (n % 50 == 0)
                    tx_idle_pct = (ph == 2 || $urandom_range(3) == 0) ? 0 :
                                  (ph == 0) ? 20 : 83;
                if ($urandom_range(9) < 7)
                    send_orbit();
                else
                    send_word(rand_pos(), rand_pos(), rand_pos(),
                              rand_pos(), rand_pos(), rand_pos());
            end
        end
        pos.valid <= 1'b0;
        rx_idle_pct = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (BODY_LAT + 20) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
